@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers with clock and active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds on every clock edge outside reset
`define CHECK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds on every clock edge outside reset
`define CHECK_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

@@ rtl/frms_pkg.sv @@
// ---------------------------------------------------------------------------
// frms_pkg
// Widths and constants for the frame RMS and peak level meter.
// ---------------------------------------------------------------------------
`default_nettype none

package frms_pkg;

    // Audio sample width
    localparam int SAMPLE_W = 16;

    // Default frame bound in samples
    localparam int MAX_FRAME_SAMPLES_DEF = 1024;

    // Width of one squared sample
    localparam int SQ_W = 2 * SAMPLE_W;

    // Width of the shared subtract unit
    localparam int OP_W = 32;

    // First bit weight of the digit-by-digit square root
    localparam logic [OP_W-1:0] ROOT_START = 32'h4000_0000;

    // Master-side tdata width: five fields rounded up to whole bytes
    localparam int M_TDATA_W = 72;

endpackage

`default_nettype wire

@@ rtl/frame_rms_peak_meter.sv @@
// ---------------------------------------------------------------------------
// frame_rms_peak_meter
// Passes mono samples out as stereo and reports RMS and peak per frame.
// ---------------------------------------------------------------------------
// Usage:
//   Slave side (s_tvalid/s_tready/s_tdata/s_tlast) takes one signed sample a
//   transaction; s_tlast marks the last sample of a frame. Master side
//   (m_tvalid/m_tready/m_tdata/m_tuser) returns one result per sample: the
//   sample copied to both channels and, on a frame end with report_levels
//   set, the RMS and peak levels (m_tuser high). The cfg channel writes
//   report_levels; write it only while the block is idle.
//   Each accepted sample passes the sequencer's square and accumulate steps
//   and then its final step, which loads the output register; a reporting
//   frame end inserts the bit-serial divide and square root on the shared
//   subtractor before the final step. The sequencer takes no new sample
//   until it is back in idle, so samples are handled one at a time.
//   The output register holds a result while the receiver stalls; the
//   next sample is accepted meanwhile, and the sequencer waits at its
//   final step until the output register is free.
//   Reset clears the accumulators, the output register and report_levels.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module frame_rms_peak_meter
    import frms_pkg::*;
#(
    parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // cfg_data: report_levels [0]
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [0:0]            cfg_data,
    // s_tdata: pcm_sample [15:0]
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [SAMPLE_W-1:0]   s_tdata,
    input  wire logic                  s_tlast,
    // m_tdata: left_out [15:0], right_out [31:16], rms_level [47:32],
    //          peak_level [63:48], frame_overrun [64], zero pad [71:65]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    // m_tuser: level_valid [0]
    output logic                       m_tuser
);

    localparam int COUNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int SUM_W   = SQ_W - 2 + COUNT_W;
    localparam int ITER_W  = $clog2(SUM_W);
    localparam int REM_W   = COUNT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic                   report_reg;
    logic [SAMPLE_W-1:0]    sample_reg;
    logic                   last_reg;
    logic [SAMPLE_W-1:0]    mag_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_W-1:0]    peak_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic                   ovr_reg;
    logic                   do_report_reg;
    logic [SAMPLE_W-1:0]    peak_hold_reg;
    logic                   ovr_hold_reg;
    logic [COUNT_W-1:0]     den_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [SUM_W-1:0]       div_reg;
    logic [ITER_W-1:0]      iter_reg;
    logic [OP_W-1:0]        v_reg;
    logic [OP_W-1:0]        res_reg;
    logic [OP_W-1:0]        bit_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_W-1:0]    out_sample_reg;
    logic                   out_level_valid_reg;
    logic [SAMPLE_W-1:0]    out_rms_reg;
    logic [SAMPLE_W-1:0]    out_peak_reg;
    logic                   out_ovr_reg;

    logic [SAMPLE_W-1:0]    in_mag;
    logic                   measure;
    logic [SUM_W-1:0]       acc_sum;
    logic [SAMPLE_W-1:0]    acc_peak;
    logic [COUNT_W-1:0]     acc_count;
    logic                   acc_report;
    logic [REM_W-1:0]       rem_shift;
    logic [OP_W-1:0]        op_a;
    logic [OP_W-1:0]        op_b;
    logic [OP_W:0]          op_diff;
    logic                   op_ge;
    logic [SUM_W-1:0]       div_shift;
    logic [OP_W-1:0]        res_step;
    logic                   out_free;

    // Take the magnitude of the incoming sample; the most negative maps to 0x8000
    assign in_mag = s_tdata[SAMPLE_W-1] ? (~s_tdata + SAMPLE_W'(1)) : s_tdata;

    // Measure only while the frame is below its bound
    assign measure   = (count_reg < COUNT_W'(MAX_FRAME_SAMPLES));
    assign acc_sum   = sum_reg + SUM_W'(sq_reg);
    assign acc_peak  = (mag_reg > peak_reg) ? mag_reg : peak_reg;
    assign acc_count = count_reg + COUNT_W'(1);
    assign acc_report = report_reg && last_reg && (measure || (count_reg != '0));

    // Shared subtract unit: divide remainder trial or root trial
    assign rem_shift = {rem_reg[COUNT_W-1:0], div_reg[SUM_W-1]};
    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            op_a = v_reg;
            op_b = res_reg + bit_reg;
        end
        else
        begin
            op_a = OP_W'(rem_shift);
            op_b = OP_W'(den_reg);
        end
    end
    assign op_diff = {1'b0, op_a} - {1'b0, op_b};
    assign op_ge   = ~op_diff[OP_W];

    // Quotient bits shift in from the bottom as dividend bits leave the top
    assign div_shift = {div_reg[SUM_W-2:0], op_ge};
    assign res_step  = op_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

    assign out_free = !out_valid_reg || m_tready;

    // Sequencer, datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            report_reg          <= 1'b0;
            sample_reg          <= '0;
            last_reg            <= 1'b0;
            mag_reg             <= '0;
            sq_reg              <= '0;
            sum_reg             <= '0;
            peak_reg            <= '0;
            count_reg           <= '0;
            ovr_reg             <= 1'b0;
            do_report_reg       <= 1'b0;
            peak_hold_reg       <= '0;
            ovr_hold_reg        <= 1'b0;
            den_reg             <= '0;
            rem_reg             <= '0;
            div_reg             <= '0;
            iter_reg            <= '0;
            v_reg               <= '0;
            res_reg             <= '0;
            bit_reg             <= '0;
            out_valid_reg       <= 1'b0;
            out_sample_reg      <= '0;
            out_level_valid_reg <= 1'b0;
            out_rms_reg         <= '0;
            out_peak_reg        <= '0;
            out_ovr_reg         <= 1'b0;
        end
        else
        begin
            // Write the configuration register
            if (cfg_valid)
            begin
                report_reg <= cfg_data[0];
            end

            // Drop the result once the receiver takes it; the final step reloads it
            if (out_valid_reg && m_tready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        sample_reg <= s_tdata;
                        last_reg   <= s_tlast;
                        mag_reg    <= in_mag;
                        state_reg  <= ST_SQUARE;
                    end
                end

                ST_SQUARE:
                begin
                    sq_reg    <= mag_reg * mag_reg;
                    state_reg <= ST_ACCUM;
                end

                ST_ACCUM:
                begin
                    if (last_reg)
                    begin
                        // Hand the frame totals to the report path, clear for the next frame
                        do_report_reg <= acc_report;
                        peak_hold_reg <= measure ? acc_peak : peak_reg;
                        ovr_hold_reg  <= ovr_reg || !measure;
                        den_reg       <= measure ? acc_count : count_reg;
                        div_reg       <= measure ? acc_sum : sum_reg;
                        rem_reg       <= '0;
                        iter_reg      <= ITER_W'(SUM_W - 1);
                        sum_reg       <= '0;
                        peak_reg      <= '0;
                        count_reg     <= '0;
                        ovr_reg       <= 1'b0;
                        state_reg     <= acc_report ? ST_DIV : ST_DONE;
                    end
                    else
                    begin
                        do_report_reg <= 1'b0;
                        ovr_hold_reg  <= 1'b0;
                        if (measure)
                        begin
                            sum_reg   <= acc_sum;
                            peak_reg  <= acc_peak;
                            count_reg <= acc_count;
                        end
                        else
                        begin
                            ovr_reg <= 1'b1;
                        end
                        state_reg <= ST_DONE;
                    end
                end

                ST_DIV:
                begin
                    // One restoring divide step per cycle
                    rem_reg  <= op_ge ? op_diff[REM_W-1:0] : rem_shift;
                    div_reg  <= div_shift;
                    iter_reg <= iter_reg - ITER_W'(1);
                    if (iter_reg == '0)
                    begin
                        v_reg     <= OP_W'(div_shift);
                        res_reg   <= '0;
                        bit_reg   <= ROOT_START;
                        state_reg <= ST_SQRT;
                    end
                end

                ST_SQRT:
                begin
                    // One root digit per cycle
                    if (op_ge)
                    begin
                        v_reg <= op_diff[OP_W-1:0];
                    end
                    res_reg <= res_step;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        state_reg <= ST_DONE;
                    end
                end

                ST_DONE:
                begin
                    // Load the output register once it is free
                    if (out_free)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_sample_reg      <= sample_reg;
                        out_level_valid_reg <= do_report_reg;
                        out_rms_reg         <= do_report_reg ? res_reg[SAMPLE_W-1:0] : '0;
                        out_peak_reg        <= do_report_reg ? peak_hold_reg : '0;
                        out_ovr_reg         <= ovr_hold_reg;
                        state_reg           <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_level_valid_reg;
    assign m_tdata   = {7'b0, out_ovr_reg, out_peak_reg, out_rms_reg,
                        out_sample_reg, out_sample_reg};

    // The RMS level of a frame never exceeds its peak
    `CHECK_IMPLY(a_rms_le_peak, clk, rst_n, m_tvalid && m_tuser, out_rms_reg <= out_peak_reg, "rms above peak")

    // Level fields stay zero when no report is carried
    `CHECK_IMPLY(a_levels_zero, clk, rst_n, m_tvalid && !m_tuser, (out_rms_reg == '0) && (out_peak_reg == '0), "levels without report")

    // The frame count stays within its bound, and overrun only at the bound
    `CHECK_ALWAYS(a_count_bound, clk, rst_n, (count_reg <= COUNT_W'(MAX_FRAME_SAMPLES)) && (!ovr_reg || (count_reg == COUNT_W'(MAX_FRAME_SAMPLES))), "frame count out of bound")

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Stream test of the frame RMS and peak level meter. Drives signed mono
// samples in frames, toggles level reporting between phases, and checks
// every stereo result and frame report against an in-bench level predictor.
// ---------------------------------------------------------------------------

module tb;
    import frms_pkg::*;

    localparam int     FRAME_BOUND = MAX_FRAME_SAMPLES_DEF;
    localparam int     IDLE_PCT    = 17;
    localparam int     MAX_SHOWN   = 10;
    localparam int     TAIL_CYCLES = 100;
    localparam longint LIMIT_NS    = 64'd10_000_000;

    // Result word in m_tdata order, lowest field last
    typedef struct packed {
        logic [6:0]          pad;
        logic                overrun;
        logic [15:0]         peak;
        logic [15:0]         rms;
        logic [SAMPLE_W-1:0] right;
        logic [SAMPLE_W-1:0] left;
    } meter_word_t;

    typedef struct packed {
        meter_word_t word;
        logic        level_valid;
    } meter_result_t;

    typedef enum int {SMP_ANY, SMP_EDGE, SMP_QUIET, SMP_FULL_NEG, SMP_MIX} sample_style_t;

    // -----------------------------------------------------------------------
    // Level predictor and store of pending stereo results
    // -----------------------------------------------------------------------
    class level_scoreboard;
        bit              report_en;
        longint unsigned sq_sum;
        int unsigned     peak_mag;
        int unsigned     n_measured;
        bit              overrun_seen;
        meter_result_t   result_q[$];
        int              n_errors;

        function int pending();
            return result_q.size();
        endfunction

        // Floor of the square root, one result bit at a time
        function int unsigned floor_root(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 16; b >= 0; b--)
            begin
                t = r | (longint'(1) << b);
                if (t * t <= v)
                    r = t;
            end
            return int'(r);
        endfunction

        // Accumulate one accepted sample and queue its result
        function void note_sample(logic [SAMPLE_W-1:0] pcm, logic last);
            int unsigned   mag;
            meter_result_t r;
            mag = pcm[SAMPLE_W-1] ? 32'd65536 - 32'(pcm) : 32'(pcm);
            if (n_measured < FRAME_BOUND)
            begin
                sq_sum += longint'(mag) * longint'(mag);
                if (mag > peak_mag)
                    peak_mag = mag;
                n_measured++;
            end
            else
                overrun_seen = 1'b1;
            r = '0;
            r.word.left  = pcm;
            r.word.right = pcm;
            if (last)
            begin
                r.word.overrun = overrun_seen;
                if (report_en && n_measured != 0)
                begin
                    r.level_valid = 1'b1;
                    r.word.rms    = 16'(floor_root(sq_sum / n_measured));
                    r.word.peak   = 16'(peak_mag);
                end
                sq_sum       = 0;
                peak_mag     = 0;
                n_measured   = 0;
                overrun_seen = 1'b0;
            end
            result_q.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(meter_word_t word, logic level_valid);
            meter_result_t want;
            if (result_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("unexpected result: tdata %h tuser %b", word, level_valid);
                return;
            end
            want = result_q.pop_front();
            if (word !== want.word || level_valid !== want.level_valid)
            begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                begin
                    $display("mismatch: exp L %h R %h valid %b rms %h peak %h ovr %b pad %h",
                             want.word.left, want.word.right, want.level_valid,
                             want.word.rms, want.word.peak, want.word.overrun, want.word.pad);
                    $display("          got L %h R %h valid %b rms %h peak %h ovr %b pad %h",
                             word.left, word.right, level_valid,
                             word.rms, word.peak, word.overrun, word.pad);
                end
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [0:0]           cfg_data  = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [SAMPLE_W-1:0]  s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tready  = 1'b0;
    logic                 steady    = 1'b0;
    wire                  cfg_ready;
    wire                  s_tready;
    wire                  m_tvalid;
    wire [M_TDATA_W-1:0]  m_tdata;
    wire                  m_tuser;

    level_scoreboard      board;
    int                   samples_sent = 0;

    frame_rms_peak_meter #(
        .MAX_FRAME_SAMPLES (FRAME_BOUND)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // pcm_sample [15:0]
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // left [15:0], right [31:16], rms [47:32], peak [63:48],
                                // overrun [64], pad [71:65]
        .m_tuser   (m_tuser)    // level_valid [0]
    );

    always #5 clk = ~clk;

    // Stall the result side at random, except in the steady stretch
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    // Check each result transaction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(meter_word_t'(m_tdata), m_tuser);
    end

    // Write report_levels once every pending result has drained
    task automatic write_report(logic en);
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid       <= 1'b0;
        board.report_en  = en;
    endtask

    // Offer one sample and hold it until the transaction completes
    task automatic send_sample(logic [SAMPLE_W-1:0] pcm, logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pcm;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        board.note_sample(pcm, last);
        samples_sent++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(sample_style_t style);
        logic [SAMPLE_W-1:0] pcm;
        sample_style_t       s;
        s = style;
        if (s == SMP_MIX)
            s = sample_style_t'($urandom_range(2));
        case (s)
            SMP_EDGE:
                case ($urandom_range(4))
                    0:       pcm = 16'h8000;
                    1:       pcm = 16'h7FFF;
                    2:       pcm = 16'h0000;
                    3:       pcm = 16'h0001;
                    default: pcm = 16'hFFFF;
                endcase
            SMP_QUIET:
            begin
                pcm = 16'($urandom_range(255));
                if ($urandom_range(1))
                    pcm = -pcm;
            end
            SMP_FULL_NEG: pcm = 16'h8000;
            default:      pcm = 16'($urandom);
        endcase
        return pcm;
    endfunction

    task automatic send_frame(int len, sample_style_t style);
        for (int i = 0; i < len; i++)
            send_sample(pick_sample(style), i == len - 1);
    endtask

    // Send whole frames of random length and content up to a sample quota
    task automatic random_frames(int quota);
        int            start;
        int            r;
        int            len;
        sample_style_t style;
        start = samples_sent;
        while (samples_sent - start < quota)
        begin
            r = $urandom_range(99);
            if (r < 70)
                len = $urandom_range(16, 1);
            else if (r < 95)
                len = $urandom_range(64, 17);
            else
                len = $urandom_range(200, 65);
            r = $urandom_range(99);
            if (r < 40)
                style = SMP_ANY;
            else if (r < 60)
                style = SMP_EDGE;
            else if (r < 75)
                style = SMP_QUIET;
            else
                style = SMP_MIX;
            send_frame(len, style);
        end
    endtask

    // Stimulus
    initial
    begin
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reporting is off out of reset
        send_sample(16'h0064, 1'b0);
        send_sample(16'hFF9C, 1'b0);
        send_sample(16'h0007, 1'b1);

        // Single-sample frames at the extremes, then mixed short frames
        write_report(1'b1);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b1);

        // Frame end with reporting disabled
        write_report(1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);

        // Full-scale frame past the bound, then random frames
        write_report(1'b1);
        send_frame($urandom_range(FRAME_BOUND + 3, FRAME_BOUND + 1), SMP_FULL_NEG);
        random_frames(300);

        // Reporting off, no idling on either side
        write_report(1'b0);
        steady <= 1'b1;
        random_frames(250);
        steady <= 1'b0;

        // Reporting on again
        write_report(1'b1);
        random_frames(200);

        // Drain and let the last report settle
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.n_errors == 0 && board.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
